// ===== hdl/dict_pkg.sv =====
// ----------------------------------------------------------------------------
// dict_pkg: shared types and constants of the discrete input counter/tacho
// Commands, channel modes, register indexes, output layout, control structs.
// ----------------------------------------------------------------------------
package dict_pkg;

  localparam int MAX_CH = 4;
  localparam int CHAN_W = 2;
  localparam int CNT_W  = 32;
  localparam int SPD_W  = 16;
  localparam int RPT_W  = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_RESET  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [2:0] MODE_NORMAL    = 3'd0;
  localparam logic [2:0] MODE_COUNTER   = 3'd1;
  localparam logic [2:0] MODE_TACHO     = 3'd2;
  localparam logic [2:0] MODE_ENC       = 3'd3;
  localparam logic [2:0] MODE_ENC_TACHO = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CSP0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CSP1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CSP2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CSP3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODES   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLES = 3'd7;

  // output tdata layout
  localparam int OUT_ACC_BIT = 53;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  typedef struct packed {
    logic item_ld;
    logic exec;
    logic emit;
  } dict_ctl_t;

  typedef struct packed {
    logic rpt_none;
    logic rpt_last;
    logic out_free;
  } dict_stat_t;

endpackage

// ===== hdl/dict_ctrl.sv =====
// ----------------------------------------------------------------------------
// dict_ctrl: sequencer of the discrete input counter/tacho
// Accepts one item, runs its update, then hands out results one a cycle while out_free.
// ----------------------------------------------------------------------------
module dict_ctrl import dict_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dict_stat_t stat,
  output dict_ctl_t  ctl
);

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ctl.item_ld = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (stat.rpt_none) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          ctl.emit = 1'b1;
          if (stat.rpt_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/dict_dp.sv =====
// ----------------------------------------------------------------------------
// dict_dp: datapath of the discrete input counter/tacho
// Config registers, per-channel counter lanes, result list and output register.
// ----------------------------------------------------------------------------
module dict_dp import dict_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  dict_ctl_t             ctl,
  output dict_stat_t            stat
);

  // configuration
  logic [CNT_W-1:0] count_sp [MAX_CH];
  logic [31:0]      spd_lo;
  logic [31:0]      spd_hi;
  logic [11:0]      modes;
  logic [7:0]       enables;
  logic [63:0]      spd_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CH; i++) count_sp[i] <= '0;
      spd_lo  <= '0;
      spd_hi  <= '0;
      modes   <= '0;
      enables <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CSP0:    count_sp[0] <= cfg_wdata;
        REG_CSP1:    count_sp[1] <= cfg_wdata;
        REG_CSP2:    count_sp[2] <= cfg_wdata;
        REG_CSP3:    count_sp[3] <= cfg_wdata;
        REG_SPD_LO:  spd_lo      <= cfg_wdata;
        REG_SPD_HI:  spd_hi      <= cfg_wdata;
        REG_MODES:   modes       <= cfg_wdata[11:0];
        REG_ENABLES: enables     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign spd_all = {spd_hi, spd_lo};

  // latched item
  cmd_t              cmd_r;
  logic [CHAN_W-1:0] ch_r;
  logic              lvl_r;

  always_ff @(posedge clk) begin
    if (ctl.item_ld) begin
      cmd_r <= cmd_t'(s_tuser);
      ch_r  <= s_tdata[CHAN_W-1:0];
      lvl_r <= s_tdata[CHAN_W];
    end
  end

  logic ch_valid;
  logic pair_valid;
  logic do_sample;
  logic do_tick;
  logic do_reset;

  assign ch_valid   = int'(ch_r) < CHANNELS;
  assign pair_valid = int'(ch_r ^ CHAN_W'(1)) < CHANNELS;
  assign do_sample  = ctl.exec && (cmd_r == CMD_SAMPLE) && ch_valid;
  assign do_tick    = ctl.exec && (cmd_r == CMD_TICK);
  assign do_reset   = ctl.exec && (cmd_r == CMD_RESET) && ch_valid;

  // channel lanes
  logic             prev       [MAX_CH];
  logic [CNT_W-1:0] edge_cnt   [MAX_CH];
  logic [SPD_W-1:0] live       [MAX_CH];
  logic [SPD_W-1:0] hold       [MAX_CH];
  logic             cflag      [MAX_CH];
  logic             sflag      [MAX_CH];
  logic             prev_next  [MAX_CH];
  logic [CNT_W-1:0] edge_next  [MAX_CH];
  logic [SPD_W-1:0] live_next  [MAX_CH];
  logic [SPD_W-1:0] hold_next  [MAX_CH];
  logic             cflag_next [MAX_CH];
  logic             sflag_next [MAX_CH];
  logic [MAX_CH-1:0] allowed_v;
  logic [MAX_CH-1:0] chg_v;

  for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
    localparam int P    = c ^ 1;
    localparam bit ACTV = (c < CHANNELS);
    localparam bit HAS_P = (P < CHANNELS);
    localparam bit ODD  = ((c % 2) == 1);

    logic [2:0]       m;
    logic [2:0]       m_p;
    logic [SPD_W-1:0] sp_spd;
    logic [CNT_W-1:0] edge_inc;
    logic             hit;
    logic             pair_hit;
    logic             rise;
    logic             rise_p;
    logic             pair_low;
    logic             reload;
    logic             inc_live;
    logic             inc_edge;
    logic             clr;

    assign m        = ACTV  ? modes[3*c +: 3] : MODE_NORMAL;
    assign m_p      = HAS_P ? modes[3*P +: 3] : MODE_NORMAL;
    assign sp_spd   = spd_all[SPD_W*c +: SPD_W];
    assign edge_inc = edge_cnt[c] + CNT_W'(1);
    assign hit      = ACTV && (ch_r == CHAN_W'(c));
    assign pair_hit = ACTV && HAS_P && (ch_r == CHAN_W'(P));
    assign rise     = lvl_r && !prev[c];
    assign rise_p   = lvl_r && !prev[P];
    assign pair_low = !(HAS_P && prev[P]);
    assign reload   = ACTV && ((m == MODE_TACHO) || (ODD && (m == MODE_ENC_TACHO)));

    assign allowed_v[c] = !(ODD && (m >= MODE_ENC));
    assign chg_v[c]     = reload && (live[c] != hold[c]);

    // encoder plus tacho feeds the odd phase's live count
    assign inc_live = do_sample && (
        (hit && (m == MODE_TACHO) && rise) ||
        (ODD && ((hit && (m == MODE_ENC_TACHO) && rise) ||
                 (pair_hit && (m_p == MODE_ENC_TACHO) && rise_p))));
    assign inc_edge = do_sample && hit && rise &&
        ((m == MODE_COUNTER) || (((m == MODE_ENC) || (m == MODE_ENC_TACHO)) && pair_low));
    assign clr = do_reset && lvl_r &&
        ((hit && allowed_v[c]) || (ODD && pair_hit && (m_p >= MODE_ENC)));

    assign prev_next[c]  = (do_sample && hit) ? lvl_r : prev[c];
    assign edge_next[c]  = clr ? '0 : (inc_edge ? edge_inc : edge_cnt[c]);
    assign cflag_next[c] = clr      ? (enables[c] && (count_sp[c] == '0)) :
                           inc_edge ? (enables[c] && (edge_inc >= count_sp[c])) : cflag[c];
    assign live_next[c]  = (do_tick && reload) ? '0 :
                           (inc_live ? live[c] + SPD_W'(1) : live[c]);
    assign hold_next[c]  = clr ? '0 : ((do_tick && reload) ? live[c] : hold[c]);
    assign sflag_next[c] = clr ? (enables[4+c] && (sp_spd == '0)) :
                           (do_tick && reload) ? (enables[4+c] && (live[c] >= sp_spd)) :
                           sflag[c];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CH; i++) begin
        prev[i]     <= 1'b0;
        edge_cnt[i] <= '0;
        live[i]     <= '0;
        hold[i]     <= '0;
        cflag[i]    <= 1'b0;
        sflag[i]    <= 1'b0;
      end
    end else begin
      prev     <= prev_next;
      edge_cnt <= edge_next;
      live     <= live_next;
      hold     <= hold_next;
      cflag    <= cflag_next;
      sflag    <= sflag_next;
    end
  end

  // result list, built at execute time
  logic [CHAN_W-1:0] lst [MAX_CH];
  logic [RPT_W-1:0]  lst_n;
  logic              lst_acc;

  always_comb begin
    for (int i = 0; i < MAX_CH; i++) lst[i] = '0;
    lst_n   = '0;
    lst_acc = 1'b1;
    case (cmd_r)
      CMD_TICK: begin
        for (int i = 0; i < MAX_CH; i++) begin
          if (chg_v[i]) begin
            lst[lst_n[CHAN_W-1:0]] = CHAN_W'(i);
            lst_n = lst_n + RPT_W'(1);
          end
        end
      end
      CMD_SAMPLE: begin
        lst[0] = ch_r;
        lst_n  = ch_valid ? RPT_W'(1) : '0;
      end
      CMD_RESET: begin
        lst[0] = ch_r;
        lst[1] = ch_r ^ CHAN_W'(1);
        if (ch_valid) begin
          if (!allowed_v[ch_r]) begin
            lst_acc = 1'b0;
            lst_n   = RPT_W'(1);
          end else begin
            lst_n = pair_valid ? RPT_W'(2) : RPT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  logic [CHAN_W-1:0] rpt_ch [MAX_CH];
  logic [RPT_W-1:0]  rpt_cnt;
  logic [CHAN_W-1:0] rpt_idx;
  logic              rpt_acc;
  logic [CHAN_W-1:0] sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_cnt <= '0;
      rpt_idx <= '0;
    end else if (ctl.exec) begin
      rpt_cnt <= lst_n;
      rpt_idx <= '0;
    end else if (ctl.emit) begin
      rpt_idx <= rpt_idx + CHAN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      rpt_ch  <= lst;
      rpt_acc <= lst_acc;
    end
  end

  assign sel = rpt_ch[rpt_idx];

  // output register
  logic              out_valid;
  logic [CHAN_W-1:0] out_ch;
  logic              out_lvl;
  logic [CNT_W-1:0]  out_cnt;
  logic [SPD_W-1:0]  out_spd;
  logic              out_cr;
  logic              out_sr;
  logic              out_acc;
  logic              out_last;

  assign stat.rpt_none = (rpt_cnt == '0);
  assign stat.rpt_last = ({1'b0, rpt_idx} == (rpt_cnt - RPT_W'(1)));
  assign stat.out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_ch   <= sel;
      out_lvl  <= prev[sel];
      out_cnt  <= edge_cnt[sel];
      out_spd  <= hold[sel];
      out_cr   <= cflag[sel];
      out_sr   <= sflag[sel];
      out_acc  <= rpt_acc;
      out_last <= stat.rpt_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_acc, out_sr, out_cr, out_spd, out_cnt, out_lvl, out_ch};

endmodule

// ===== hdl/discrete_input_counter_tacho_top.sv =====
// ----------------------------------------------------------------------------
// discrete_input_counter_tacho_top: four-channel pulse counter and tachometer
// Input items carry pin samples, reload ticks and channel resets.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one item: s_tuser = command, s_tdata = channel, level.
//   m_* channel returns the results of an item, m_tlast on the final one.
//   cfg_we/cfg_index/cfg_wdata write the setpoint, mode and enable registers;
//   write them only while no item is in flight.
// Sequence:
//   an item is accepted, executed in the next cycle and its first result is
//   registered in the report state; the following results come one per cycle
//   while the output is free. A sample gives at most one result, a reset at
//   most two, a tick one per channel whose speed value changed; some give none.
//   Results leave through the accept/execute/report sequencer and the single
//   output register that hands out one result per cycle when it is free.
// Reset: rst clears the config registers, counts, speed values and flags.
// Stall: while m_tready is low the pending result holds; once the last result
//   is registered the block takes and runs the next item, then waits to report it.
// ----------------------------------------------------------------------------
module discrete_input_counter_tacho_top import dict_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // channel[1:0], level[2], zero pad
  input  logic [1:0]            s_tuser,   // command[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // chan_out[1:0], pin_level[2], event_count[34:3], speed_value[50:35],
  // count_reached[51], speed_reached[52], accepted[53], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast    // last
);

  dict_ctl_t  ctl;
  dict_stat_t stat;

  dict_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  dict_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

// ===== hdl/dict_chk.sv =====
// ----------------------------------------------------------------------------
// dict_chk: port checker of the discrete input counter/tacho
// Watches the top level's stream ports; bound to the top level below.
// ----------------------------------------------------------------------------
module dict_chk import dict_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OUT_ACC_BIT] |-> m_tlast)
    else $error("rejected reset gave more than one result");

endmodule

bind discrete_input_counter_tacho_top dict_chk u_dict_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
